// ===== rtl/core/shc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shc_pkg
// Shared types, widths and helpers for the seed hit clusterer.
// ----------------------------------------------------------------------------
package shc_pkg;

  localparam int unsigned ID_W        = 32;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned HIT_W       = ID_W + POS_W;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned TOL_W       = 8;
  localparam int unsigned NEED_W      = 8;
  localparam int unsigned MINZ_W      = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_POS_TOL      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SEEDS_NEEDED = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MINZ_TOTAL   = CFG_IDX_W'(2);

  localparam logic [TOL_W-1:0]  POS_TOL_RST      = TOL_W'(8);
  localparam logic [NEED_W-1:0] SEEDS_NEEDED_RST = NEED_W'(2);
  localparam logic [MINZ_W-1:0] MINZ_TOTAL_RST   = MINZ_W'(100);

  typedef enum logic {
    ITEM_HIT,
    ITEM_END
  } item_kind_t;

  typedef struct packed {
    item_kind_t       kind;
    logic [HIT_W-1:0] hit;
  } shc_word_t;

  typedef struct packed {
    logic [TOL_W-1:0]  position_tolerance;
    logic [NEED_W-1:0] seeds_needed;
    logic [MINZ_W-1:0] minimizer_total;
  } shc_cfg_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/shc_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shc_ifs
// Valid/ready channels for hits, candidates and register writes.
// ----------------------------------------------------------------------------
interface shc_hit_if;
  logic                      valid;
  logic                      ready;
  logic [shc_pkg::ID_W-1:0]  ref_id;
  logic [shc_pkg::POS_W-1:0] ref_pos;
  logic                      end_of_hits;
  modport source(output valid, ref_id, ref_pos, end_of_hits, input ready);
  modport sink(input valid, ref_id, ref_pos, end_of_hits, output ready);
endinterface

interface shc_cand_if;
  logic                      valid;
  logic                      ready;
  logic [shc_pkg::ID_W-1:0]  cand_ref_id;
  logic [shc_pkg::POS_W-1:0] cand_ref_pos;
  logic [shc_pkg::CNT_W-1:0] cand_support;
  modport source(output valid, cand_ref_id, cand_ref_pos, cand_support, input ready);
  modport sink(input valid, cand_ref_id, cand_ref_pos, cand_support, output ready);
endinterface

interface shc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [shc_pkg::CFG_IDX_W-1:0]  index;
  logic [shc_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/shc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shc_front
// Input stage: registers each word and tags it as a hit or an end marker.
// ----------------------------------------------------------------------------
module shc_front (
  input  logic               clk,
  input  logic               rst,
  shc_hit_if.sink            hits,
  output shc_pkg::shc_word_t word,
  output logic               word_valid,
  input  logic               word_ready
);
  import shc_pkg::*;

  assign hits.ready = !word_valid || word_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (hits.ready) begin
      word_valid <= hits.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hits.valid && hits.ready) begin
      word.kind <= hits.end_of_hits ? ITEM_END : ITEM_HIT;
      word.hit  <= {hits.ref_id, hits.ref_pos};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/shc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shc_queue
// Short FIFO between the input stage and the cluster engine.
// ----------------------------------------------------------------------------
module shc_queue (
  input  logic               clk,
  input  logic               rst,
  input  shc_pkg::shc_word_t push_word,
  input  logic               push_valid,
  output logic               push_ready,
  output shc_pkg::shc_word_t pop_word,
  output logic               pop_valid,
  input  logic               pop_ready
);
  import shc_pkg::*;

  localparam logic [QPTR_W:0]   FULL_FILL = (QPTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);

  shc_word_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              push;
  logic              pop;

  assign push_ready = (fill != FULL_FILL);
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_word   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_ptr_fill: assert property (@(posedge clk) disable iff (rst)
    ((wr_ptr == rd_ptr) == (fill == '0 || fill == FULL_FILL)))
    else $error("queue pointers disagree with fill count");

  a_fill_inc: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (fill == $past(fill) + 1'b1))
    else $error("queue fill count missed a push");

endmodule
`default_nettype wire

// ===== rtl/core/shc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shc_back
// Cluster engine: tracks the open cluster and its most repeated hit, and
// registers a candidate whenever a cluster with enough seeds closes.
// ----------------------------------------------------------------------------
module shc_back (
  input  logic               clk,
  input  logic               rst,
  input  shc_pkg::shc_cfg_t  cfg_regs,
  input  shc_pkg::shc_word_t head,
  input  logic               head_valid,
  output logic               head_ready,
  shc_cand_if.source         cands
);
  import shc_pkg::*;

  logic              cluster_open;
  logic [HIT_W-1:0]  prev_hit;
  logic [HIT_W-1:0]  best_hit;
  logic [CNT_W-1:0]  seed_count;
  logic [CNT_W-1:0]  run_count;
  logic [CNT_W-1:0]  best_run_count;

  logic              out_valid;
  logic [ID_W-1:0]   out_id;
  logic [POS_W-1:0]  out_pos;
  logic [CNT_W-1:0]  out_support;

  logic              pop;
  logic              is_end;
  logic [ID_W-1:0]   hit_id;
  logic [POS_W-1:0]  hit_pos;
  logic [POS_W-1:0]  prev_lim;
  logic [POS_W-1:0]  best_lim;
  logic              split;
  logic              closing;
  logic              emit;
  logic [CNT_W-1:0]  run_inc;

  assign head_ready = !out_valid || cands.ready;
  assign pop        = head_valid && head_ready;
  assign is_end     = (head.kind == ITEM_END);
  assign hit_id     = head.hit[HIT_W-1:POS_W];
  assign hit_pos    = head.hit[POS_W-1:0];

  // limits wrap at the position width
  assign prev_lim = prev_hit[POS_W-1:0] + POS_W'(cfg_regs.position_tolerance);
  assign best_lim = best_hit[POS_W-1:0] + POS_W'(cfg_regs.position_tolerance);

  assign split = (hit_id != prev_hit[HIT_W-1:POS_W]) || (hit_pos > prev_lim) ||
                 ((seed_count >= cfg_regs.minimizer_total) && (hit_pos > best_lim));
  assign closing = cluster_open && (is_end || split);
  assign emit    = closing && (seed_count >= CNT_W'(cfg_regs.seeds_needed));
  assign run_inc = sat_inc(run_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_open   <= 1'b0;
      prev_hit       <= '0;
      best_hit       <= '0;
      seed_count     <= '0;
      run_count      <= '0;
      best_run_count <= '0;
    end else if (pop) begin
      if (is_end) begin
        cluster_open <= 1'b0;
      end else if (!cluster_open || split) begin
        cluster_open   <= 1'b1;
        prev_hit       <= head.hit;
        best_hit       <= head.hit;
        seed_count     <= CNT_W'(1);
        run_count      <= CNT_W'(1);
        best_run_count <= CNT_W'(1);
      end else begin
        if (head.hit == best_hit) begin
          run_count      <= run_inc;
          best_run_count <= sat_inc(best_run_count);
        end else if (head.hit == prev_hit) begin
          run_count <= run_inc;
          if (run_inc > best_run_count) begin
            best_hit       <= prev_hit;
            best_run_count <= run_inc;
          end
        end else begin
          run_count <= CNT_W'(1);
        end
        seed_count <= sat_inc(seed_count);
        prev_hit   <= head.hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (head_ready) begin
      out_valid <= pop && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_id      <= best_hit[HIT_W-1:POS_W];
      out_pos     <= best_hit[POS_W-1:0];
      out_support <= best_run_count;
    end
  end

  assign cands.valid        = out_valid;
  assign cands.cand_ref_id  = out_id;
  assign cands.cand_ref_pos = out_pos;
  assign cands.cand_support = out_support;

  a_counts: assert property (@(posedge clk) disable iff (rst)
    cluster_open |-> (run_count != '0 && run_count <= best_run_count &&
                      best_run_count <= seed_count))
    else $error("cluster counters out of order");

  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop))
    else $error("candidate appeared without a consumed word");

  a_end_close: assert property (@(posedge clk) disable iff (rst)
    (pop && is_end) |=> !cluster_open)
    else $error("end marker left a cluster open");

endmodule
`default_nettype wire

// ===== rtl/core/seed_hit_clusterer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seed_hit_clusterer
// Groups a sorted stream of seed hits into clusters and reports the most
// repeated hit of each closed cluster that holds enough seeds.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                      handshake
//  hits      in   ref_id, ref_pos, end_of_hits                 valid/ready
//  cands     out  cand_ref_id, cand_ref_pos, cand_support      valid/ready
//  cfg       in   index (0 tol, 1 seeds, 2 minimizers), data   valid/ready
//
//  One word per cycle sustained unless the engine stalls; the cluster engine
//  state is registered. A candidate is registered in the engine's candidate
//  register once the word closing its cluster has passed the input stage and queue.
//  Synchronous reset clears control state and loads register defaults.
//  A four-word queue sits between input stage and engine; the engine stalls
//  only when the candidate register is full and not taken.
//  cfg is always ready; writes to index 3 are dropped.
// ----------------------------------------------------------------------------
module seed_hit_clusterer (
  input  logic       clk,
  input  logic       rst,
  shc_hit_if.sink    hits,
  shc_cand_if.source cands,
  shc_cfg_if.sink    cfg
);
  import shc_pkg::*;

  shc_cfg_t  cfg_regs;
  shc_word_t front_word;
  logic      front_valid;
  logic      front_ready;
  shc_word_t head_word;
  logic      head_valid;
  logic      head_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.position_tolerance <= POS_TOL_RST;
      cfg_regs.seeds_needed       <= SEEDS_NEEDED_RST;
      cfg_regs.minimizer_total    <= MINZ_TOTAL_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_POS_TOL:      cfg_regs.position_tolerance <= cfg.data[TOL_W-1:0];
        REG_SEEDS_NEEDED: cfg_regs.seeds_needed       <= cfg.data[NEED_W-1:0];
        REG_MINZ_TOTAL:   cfg_regs.minimizer_total    <= cfg.data[MINZ_W-1:0];
        default: ;
      endcase
    end
  end

  shc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .hits       (hits),
    .word       (front_word),
    .word_valid (front_valid),
    .word_ready (front_ready)
  );

  shc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_word  (front_word),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_word   (head_word),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready)
  );

  shc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_regs   (cfg_regs),
    .head       (head_word),
    .head_valid (head_valid),
    .head_ready (head_ready),
    .cands      (cands)
  );

endmodule
`default_nettype wire
